// File: rtl/refcounted_linear_probe_table_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the reference-counted probe table
// Implication and next-cycle implication checks on a clock and a reset.
// ----------------------------------------------------------------------------
`ifndef REFCOUNTED_LINEAR_PROBE_TABLE_ASSERT_SVH
`define REFCOUNTED_LINEAR_PROBE_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RLPT_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("rlpt assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define RLPT_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("rlpt assertion failed");

`endif

// File: rtl/rlpt_pkg.sv
// ----------------------------------------------------------------------------
// rlpt_pkg
// Types, codes and sizes shared by the probe table modules.
// ----------------------------------------------------------------------------
package rlpt_pkg;

   localparam int SLOT_BITS  = 10;
   localparam int SLOTS      = 1 << SLOT_BITS;
   localparam int STEP_BITS  = SLOT_BITS + 1;
   localparam int KEY_BITS   = 64;
   localparam int HASH_BITS  = 64;
   localparam int REF_BITS   = 32;
   localparam int COUNT_BITS = 10;
   localparam int LOAD_LIMIT = SLOTS * 3 / 4;

   typedef logic [SLOT_BITS-1:0]  slot_type;
   typedef logic [STEP_BITS-1:0]  step_type;
   typedef logic [COUNT_BITS-1:0] count_type;
   typedef logic [REF_BITS-1:0]   refs_type;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_CLEAR   = 2'd2,
      CMD_LOOKUP  = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_ADDED     = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_EVICTED   = 3'd3,
      ST_NOT_FOUND = 3'd4,
      ST_FULL      = 3'd5,
      ST_CLEARED   = 3'd6,
      ST_PRESENT   = 3'd7
   } status_type;

   typedef enum logic [2:0] {
      S_SWEEP,
      S_IDLE,
      S_PROBE,
      S_EVICT_CHK,
      S_EVICT_CLR,
      S_RESP
   } state_type;

   typedef struct packed {
      logic                 valid;
      logic [KEY_BITS-1:0]  key;
      logic [HASH_BITS-1:0] hash;
      refs_type             refs;
   } entry_type;

   localparam refs_type REFS_MAX = '1;

endpackage

// File: rtl/rlpt_ram.sv
// ----------------------------------------------------------------------------
// rlpt_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rlpt_ram #(
   parameter int WIDTH     = 8,
   parameter int ADDR_BITS = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [(1 << ADDR_BITS)];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/refcounted_linear_probe_table.sv
// After reset the block runs a clearing pass over every slot of the slot
// memory and accepts no request until it ends; a clear request runs the same
// pass. Acquire and lookup probe from the home slot up to the match or the
// first empty slot. A release that evicts then scans the slots after the freed
// slot and shifts entries back into the gap. Every step is one access to the
// slot memory, which has one write port and one read port; one request is in
// flight at a time.
// ----------------------------------------------------------------------------
// refcounted_linear_probe_table
// Reference-counted linear-probing table with backward-shift deletion.
// ----------------------------------------------------------------------------
module refcounted_linear_probe_table (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // cmd[1:0], key[65:2], key_hash[129:66], zero fill up to 136 bits
   input  logic [135:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[2:0], slot[12:3], ref_count[44:13], entry_count[54:45], zero fill
   output logic [55:0]  rsp_tdata
);

   rlpt_pkg::state_type state_ff, state_in;
   rlpt_pkg::cmd_type   cmd_ff, cmd_in;
   logic [rlpt_pkg::KEY_BITS-1:0]  key_ff, key_in;
   logic [rlpt_pkg::HASH_BITS-1:0] hash_ff, hash_in;
   rlpt_pkg::slot_type   idx_ff, idx_in;
   rlpt_pkg::slot_type   gap_ff, gap_in;
   rlpt_pkg::step_type   steps_ff, steps_in;
   rlpt_pkg::count_type  occ_ff, occ_in;
   logic                 clr_resp_ff, clr_resp_in;
   rlpt_pkg::status_type res_status_ff, res_status_in;
   rlpt_pkg::slot_type   res_slot_ff, res_slot_in;
   rlpt_pkg::refs_type   res_refs_ff, res_refs_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [55:0]          rsp_data_ff, rsp_data_in;

   logic                 wr_en;
   rlpt_pkg::slot_type   wr_addr, rd_addr;
   rlpt_pkg::entry_type  wr_data, rd_data;

   logic                 accept, hit, stop, last_probe, scan_end, move;
   logic                 sweep_last, rsp_free;
   rlpt_pkg::slot_type   idx_next, ideal, d_gap, d_scan;
   rlpt_pkg::refs_type   ref_dec;

   rlpt_ram #(
      .WIDTH     ($bits(rlpt_pkg::entry_type)),
      .ADDR_BITS (rlpt_pkg::SLOT_BITS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == rlpt_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Decisions shared by the next-state and datapath logic.
   always_comb begin
      idx_next   = rlpt_pkg::slot_type'(idx_ff + 1'b1);
      hit        = rd_data.valid && (rd_data.key == key_ff) && (rd_data.hash == hash_ff);
      stop       = !rd_data.valid || hit;
      last_probe = (steps_ff == rlpt_pkg::step_type'(rlpt_pkg::SLOTS - 1));
      scan_end   = (steps_ff == rlpt_pkg::step_type'(rlpt_pkg::SLOTS)) || !rd_data.valid;
      ideal      = rd_data.hash[rlpt_pkg::SLOT_BITS-1:0];
      d_gap      = rlpt_pkg::slot_type'(gap_ff - ideal);
      d_scan     = rlpt_pkg::slot_type'(idx_ff - ideal);
      move       = (d_gap <= d_scan);
      sweep_last = (idx_ff == rlpt_pkg::slot_type'(rlpt_pkg::SLOTS - 1));
      rsp_free   = !rsp_valid_ff || rsp_tready;
      ref_dec    = (rd_data.refs != '0) ? rlpt_pkg::refs_type'(rd_data.refs - 1'b1) : '0;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rlpt_pkg::S_SWEEP: begin
            if (sweep_last) begin
               state_in = clr_resp_ff ? rlpt_pkg::S_RESP : rlpt_pkg::S_IDLE;
            end
         end
         rlpt_pkg::S_IDLE: begin
            if (accept) begin
               state_in = (rlpt_pkg::cmd_type'(req_tdata[1:0]) == rlpt_pkg::CMD_CLEAR) ?
                          rlpt_pkg::S_SWEEP : rlpt_pkg::S_PROBE;
            end
         end
         rlpt_pkg::S_PROBE: begin
            if (stop || last_probe) begin
               if (hit && (cmd_ff == rlpt_pkg::CMD_RELEASE) && (ref_dec == '0)) begin
                  state_in = rlpt_pkg::S_EVICT_CHK;
               end else begin
                  state_in = rlpt_pkg::S_RESP;
               end
            end
         end
         rlpt_pkg::S_EVICT_CHK: begin
            if (scan_end) begin
               state_in = rlpt_pkg::S_RESP;
            end else if (move) begin
               state_in = rlpt_pkg::S_EVICT_CLR;
            end
         end
         rlpt_pkg::S_EVICT_CLR: state_in = rlpt_pkg::S_EVICT_CHK;
         rlpt_pkg::S_RESP: begin
            if (rsp_free) begin
               state_in = rlpt_pkg::S_IDLE;
            end
         end
         default: state_in = rlpt_pkg::S_SWEEP;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      key_in        = key_ff;
      hash_in       = hash_ff;
      idx_in        = idx_ff;
      gap_in        = gap_ff;
      steps_in      = steps_ff;
      occ_in        = occ_ff;
      clr_resp_in   = clr_resp_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      res_refs_in   = res_refs_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '0;
      rd_addr       = idx_ff;
      case (state_ff)
         rlpt_pkg::S_SWEEP: begin
            wr_en  = 1'b1;
            idx_in = idx_next;
         end
         rlpt_pkg::S_IDLE: begin
            rd_addr = req_tdata[66 +: rlpt_pkg::SLOT_BITS];
            if (accept) begin
               cmd_in   = rlpt_pkg::cmd_type'(req_tdata[1:0]);
               key_in   = req_tdata[2 +: rlpt_pkg::KEY_BITS];
               hash_in  = req_tdata[66 +: rlpt_pkg::HASH_BITS];
               idx_in   = req_tdata[66 +: rlpt_pkg::SLOT_BITS];
               steps_in = '0;
               if (rlpt_pkg::cmd_type'(req_tdata[1:0]) == rlpt_pkg::CMD_CLEAR) begin
                  idx_in        = '0;
                  occ_in        = '0;
                  clr_resp_in   = 1'b1;
                  res_status_in = rlpt_pkg::ST_CLEARED;
                  res_slot_in   = '0;
                  res_refs_in   = '0;
               end
            end
         end
         rlpt_pkg::S_PROBE: begin
            if (stop || last_probe) begin
               res_status_in = rlpt_pkg::ST_NOT_FOUND;
               res_slot_in   = '0;
               res_refs_in   = '0;
               case (cmd_ff)
                  rlpt_pkg::CMD_ACQUIRE: begin
                     if (hit) begin
                        wr_en   = 1'b1;
                        wr_data = rd_data;
                        if (rd_data.refs != rlpt_pkg::REFS_MAX) begin
                           wr_data.refs = rlpt_pkg::refs_type'(rd_data.refs + 1'b1);
                        end
                        res_status_in = rlpt_pkg::ST_ADDED;
                        res_slot_in   = idx_ff;
                        res_refs_in   = wr_data.refs;
                     end else if (!stop ||
                                  (occ_ff >= rlpt_pkg::count_type'(rlpt_pkg::LOAD_LIMIT))) begin
                        res_status_in = rlpt_pkg::ST_FULL;
                     end else begin
                        wr_en         = 1'b1;
                        wr_data.valid = 1'b1;
                        wr_data.key   = key_ff;
                        wr_data.hash  = hash_ff;
                        wr_data.refs  = rlpt_pkg::refs_type'(1);
                        occ_in        = rlpt_pkg::count_type'(occ_ff + 1'b1);
                        res_status_in = rlpt_pkg::ST_INSERTED;
                        res_slot_in   = idx_ff;
                        res_refs_in   = rlpt_pkg::refs_type'(1);
                     end
                  end
                  rlpt_pkg::CMD_RELEASE: begin
                     if (hit) begin
                        wr_en        = 1'b1;
                        wr_data      = rd_data;
                        wr_data.refs = ref_dec;
                        res_slot_in  = idx_ff;
                        res_refs_in  = ref_dec;
                        if (ref_dec == '0) begin
                           // Free the slot and start the backward-shift scan.
                           wr_data.valid = 1'b0;
                           if (occ_ff != '0) begin
                              occ_in = rlpt_pkg::count_type'(occ_ff - 1'b1);
                           end
                           res_status_in = rlpt_pkg::ST_EVICTED;
                           gap_in        = idx_ff;
                           idx_in        = idx_next;
                           rd_addr       = idx_next;
                           steps_in      = rlpt_pkg::step_type'(1);
                        end else begin
                           res_status_in = rlpt_pkg::ST_DROPPED;
                        end
                     end
                  end
                  rlpt_pkg::CMD_LOOKUP: begin
                     if (hit) begin
                        res_status_in = rlpt_pkg::ST_PRESENT;
                        res_slot_in   = idx_ff;
                        res_refs_in   = rd_data.refs;
                     end
                  end
                  default: begin
                     res_status_in = rlpt_pkg::ST_NOT_FOUND;
                  end
               endcase
            end else begin
               idx_in   = idx_next;
               rd_addr  = idx_next;
               steps_in = rlpt_pkg::step_type'(steps_ff + 1'b1);
            end
         end
         rlpt_pkg::S_EVICT_CHK: begin
            if (!scan_end) begin
               if (move) begin
                  wr_en   = 1'b1;
                  wr_addr = gap_ff;
                  wr_data = rd_data;
               end else begin
                  idx_in   = idx_next;
                  rd_addr  = idx_next;
                  steps_in = rlpt_pkg::step_type'(steps_ff + 1'b1);
               end
            end
         end
         rlpt_pkg::S_EVICT_CLR: begin
            // The moved entry's old slot becomes the new gap.
            wr_en    = 1'b1;
            gap_in   = idx_ff;
            idx_in   = idx_next;
            rd_addr  = idx_next;
            steps_in = rlpt_pkg::step_type'(steps_ff + 1'b1);
         end
         rlpt_pkg::S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, occ_ff, res_refs_ff, res_slot_ff, res_status_ff};
               clr_resp_in  = 1'b0;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rlpt_pkg::S_SWEEP;
         idx_ff       <= '0;
         occ_ff       <= '0;
         clr_resp_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         occ_ff       <= occ_in;
         clr_resp_ff  <= clr_resp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      gap_ff        <= gap_in;
      steps_ff      <= steps_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      res_refs_ff   <= res_refs_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule

// File: rtl/rlpt_checker.sv
// ----------------------------------------------------------------------------
// rlpt_checker
// Port-level checks on the probe table, bound to the top level.
// ----------------------------------------------------------------------------
`include "refcounted_linear_probe_table_assert.svh"

module rlpt_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [135:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [55:0]  rsp_tdata
);

   // A stalled response keeps its contents.
   `RLPT_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

   // Only one request is worked on at a time.
   `RLPT_ASSERT_NEXT(a_busy_after_req, clock, reset, req_tvalid && req_tready, !req_tready)

   // A cleared table reports no slot, no references and no entries.
   `RLPT_ASSERT_IMPLY(a_clear_zero, clock, reset, rsp_tvalid && (rsp_tdata[2:0] == rlpt_pkg::ST_CLEARED), rsp_tdata[54:3] == '0)

   // The load limit bounds the entry count.
   `RLPT_ASSERT_IMPLY(a_load_limit, clock, reset, rsp_tvalid, rsp_tdata[54:45] <= 10'(rlpt_pkg::LOAD_LIMIT))

endmodule

bind refcounted_linear_probe_table rlpt_checker u_rlpt_checker (.*);
